// ===== rtl/core/sct_pkg.sv =====
`timescale 1ns / 1ps
// Package for the pipelined Taylor sine and cosine unit: internal widths,
// pi in Q60 and the Q32 reciprocal tables of the series denominators.
// Depends on nothing; used by sine_cosine_taylor and the testbench.
package sct_pkg;

  // Port widths and default fixed-point formats.
  localparam int IN_W                = 32;
  localparam int OUT_W               = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 28;
  localparam int OUT_FRAC_BITS_DEF   = 30;

  // Internal arithmetic runs in Q32.
  localparam int Q_FRAC = 32;

  // Range reduction: values, the quotient estimate and its fraction shift.
  localparam int RED_W     = 36;
  localparam int RED_SHIFT = 34;
  localparam int K_W       = 16;

  // Series datapath widths.
  localparam int X_W     = 36;
  localparam int PROD_W  = 72;
  localparam int FAC_W   = 36;
  localparam int TERM_W  = 36;
  localparam int SUM_W   = 38;
  localparam int RCP_W   = 32;
  localparam int PF_W    = FAC_W + RCP_W;
  localparam int N_TERMS = 5;

  // pi in Q60.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Round-to-nearest Q32 reciprocals of the sine and cosine denominators.
  localparam logic [RCP_W-1:0] SIN_RCP [N_TERMS] = '{
    32'd715827883,  // 1/6
    32'd214748365,  // 1/20
    32'd102261126,  // 1/42
    32'd59652324,   // 1/72
    32'd39045157    // 1/110
  };

  localparam logic [RCP_W-1:0] COS_RCP [N_TERMS] = '{
    32'd2147483648, // 1/2
    32'd357913941,  // 1/12
    32'd143165577,  // 1/30
    32'd76695845,   // 1/56
    32'd47721859    // 1/90
  };

endpackage

// ===== rtl/core/sine_cosine_taylor.sv =====
`timescale 1ns / 1ps
// Pipelined fixed-point sine and cosine by truncated Taylor sums.
// Depends on sct_pkg for widths, pi and the reciprocal tables.
//
//  channel | ports                        | transfer
//  --------+------------------------------+---------------------------------
//  input   | start_i, busy_o, angle_i     | edge with start_i high, busy_o low
//  result  | valid_o, sine_o, cosine_o    | edge ending the cycle valid_o is high
//
// One angle is taken every cycle; busy_o stays low. Each result is registered
// through four stages of range reduction, four for the square and the
// per-term factors, two per Taylor term (multiply, then round and
// accumulate) and one for output rounding and saturation.
// Reset clears only the valid bits of the stages; there is no clearing pass.
// The receiver cannot stall, so results leave in order, one per accepted angle.
module sine_cosine_taylor
  import sct_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [IN_W-1:0]  angle_i,
  output logic                    valid_o,
  output logic signed [OUT_W-1:0] sine_o,
  output logic signed [OUT_W-1:0] cosine_o
);

  localparam int XSHIFT  = Q_FRAC - ANGLE_FRAC_BITS;
  localparam int OSH     = Q_FRAC - OUT_FRAC_BITS;
  localparam int RED_PW  = 2 * RED_W;
  localparam int LATENCY = 9 + 2 * N_TERMS;

  // pi and 2*pi rounded to the angle format.
  localparam logic [63:0] PI_A_U =
    (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_U =
    (PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS);
  localparam logic signed [RED_W-1:0] PI_A   = RED_W'(PI_A_U);
  localparam logic signed [RED_W-1:0] TWO_PI = RED_W'(TWO_PI_U);
  localparam logic [RED_W-1:0] TWO_PI_RCP = RED_W'((64'd1 << RED_SHIFT) / TWO_PI_U);

  localparam logic signed [X_W-1:0] X_LIM = X_W'(PI_A + RED_W'(1)) <<< XSHIFT;

  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (Q_FRAC - 1);
  localparam logic [PF_W-1:0]   HALF_F = PF_W'(1) << (Q_FRAC - 1);
  localparam logic [TERM_W-1:0] ONE_T  = TERM_W'(1) << Q_FRAC;

  localparam logic signed [SUM_W-1:0] OUT_HALF = SUM_W'(1) << (OSH - 1);
  localparam logic signed [SUM_W-1:0] OUT_HI   = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] OUT_LO   = -(SUM_W'(1) << (OUT_W - 1));

  typedef logic [N_TERMS-1:0][FAC_W-1:0] fac_vec_t;

  typedef struct packed {
    fac_vec_t fs;
    fac_vec_t fc;
  } facs_t;

  // A running term in sign-magnitude form with its partial sum.
  typedef struct packed {
    logic                    sgn;
    logic [TERM_W-1:0]       mag;
    logic signed [SUM_W-1:0] acc;
  } chain_t;

  typedef struct packed {
    logic                    sgn;
    logic [PROD_W-1:0]       prod;
    logic signed [SUM_W-1:0] acc;
  } prod_t;

  // Rounds |term| * factor back to Q32, flips the sign and accumulates.
  function automatic chain_t round_step(input prod_t p);
    chain_t                  r;
    logic [TERM_W-1:0]       m;
    logic signed [SUM_W-1:0] e;
    m = TERM_W'((p.prod + HALF_P) >> Q_FRAC);
    e = SUM_W'(m);
    r.sgn = ~p.sgn;
    r.mag = m;
    r.acc = p.sgn ? p.acc + e : p.acc - e;
    return r;
  endfunction

  // Q32 to the output format: round half up, then clamp.
  function automatic logic signed [OUT_W-1:0] out_round(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] u;
    logic signed [SUM_W-1:0] r;
    logic signed [OUT_W-1:0] o;
    u = v + OUT_HALF;
    r = u >>> OSH;
    if (r > OUT_HI) begin
      o = OUT_HI[OUT_W-1:0];
    end else if (r < OUT_LO) begin
      o = OUT_LO[OUT_W-1:0];
    end else begin
      o = r[OUT_W-1:0];
    end
    return o;
  endfunction

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // Range reduction
  // ---------------------------------------------------------------------------
  logic signed [RED_W-1:0] v_in;
  logic                    r1_pos_d, r1_neg_d;
  logic [RED_W-1:0]        r1_u_d;
  logic                    r1_vld_q, r1_pos_q, r1_neg_q;
  logic signed [RED_W-1:0] r1_v_q;
  logic [RED_W-1:0]        r1_u_q;

  logic [RED_PW-1:0]       red_prod;
  logic [K_W-1:0]          r2_k_d;
  logic                    r2_vld_q, r2_pos_q, r2_neg_q;
  logic signed [RED_W-1:0] r2_v_q;
  logic [K_W-1:0]          r2_k_q;

  logic [RED_W-1:0]        kt;
  logic signed [RED_W-1:0] r3_v_d;
  logic                    r3_vld_q, r3_pos_q, r3_neg_q;
  logic signed [RED_W-1:0] r3_v_q;

  logic signed [RED_W-1:0] v2;
  logic signed [X_W-1:0]   x_d;
  logic                    x_vld_q;
  logic signed [X_W-1:0]   x_q;

  assign v_in     = RED_W'(angle_i);
  assign r1_pos_d = v_in > PI_A;
  assign r1_neg_d = v_in < -PI_A;
  // Numerator of the ceiling quotient, for whichever side the angle lies on.
  assign r1_u_d   = r1_pos_d ? RED_W'(v_in - PI_A + TWO_PI - RED_W'(1))
                             : RED_W'(-PI_A - v_in + TWO_PI - RED_W'(1));

  // The reciprocal is rounded down, so the estimate is the true count of
  // 2*pi steps or one short; the last stage makes up the missing step.
  assign red_prod = RED_PW'(r1_u_q) * RED_PW'(TWO_PI_RCP);
  assign r2_k_d   = red_prod[RED_SHIFT +: K_W];

  assign kt = RED_W'(r2_k_q) * RED_W'(TWO_PI);

  always_comb begin
    if (r2_pos_q) begin
      r3_v_d = r2_v_q - $signed(kt);
    end else if (r2_neg_q) begin
      r3_v_d = r2_v_q + $signed(kt);
    end else begin
      r3_v_d = r2_v_q;
    end
  end

  always_comb begin
    if (r3_pos_q && (r3_v_q > PI_A)) begin
      v2 = r3_v_q - TWO_PI;
    end else if (r3_neg_q && (r3_v_q < -PI_A)) begin
      v2 = r3_v_q + TWO_PI;
    end else begin
      v2 = r3_v_q;
    end
  end

  assign x_d = X_W'(v2) <<< XSHIFT;

  // ---------------------------------------------------------------------------
  // Square and per-term factors x^2/n
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] x_ext;
  logic signed [PROD_W-1:0] sq_d;
  logic                     sq_vld_q;
  logic [PROD_W-1:0]        sq_q;
  logic signed [X_W-1:0]    sq_x_q;

  logic [FAC_W-1:0]         x2_d;
  logic                     x2_vld_q;
  logic [FAC_W-1:0]         x2_q;
  logic signed [X_W-1:0]    x2_x_q;

  logic [PF_W-1:0]          sin_pf_d [N_TERMS];
  logic [PF_W-1:0]          cos_pf_d [N_TERMS];
  logic [PF_W-1:0]          sin_pf_q [N_TERMS];
  logic [PF_W-1:0]          cos_pf_q [N_TERMS];
  logic                     pf_vld_q;
  logic signed [X_W-1:0]    pf_x_q;

  assign x_ext = PROD_W'(x_q);
  assign sq_d  = x_ext * x_ext;
  assign x2_d  = FAC_W'((sq_q + HALF_P) >> Q_FRAC);

  // ---------------------------------------------------------------------------
  // Term chains: two stages per term
  // ---------------------------------------------------------------------------
  chain_t sin_st_d [N_TERMS+1];
  chain_t sin_st_q [N_TERMS+1];
  chain_t cos_st_d [N_TERMS+1];
  chain_t cos_st_q [N_TERMS+1];
  logic   vld_st_q [N_TERMS+1];
  prod_t  sin_mid_d [N_TERMS];
  prod_t  sin_mid_q [N_TERMS];
  prod_t  cos_mid_d [N_TERMS];
  prod_t  cos_mid_q [N_TERMS];
  logic   vld_mid_q [N_TERMS];
  facs_t  fac_st_d;
  facs_t  fac_st_q [N_TERMS];
  facs_t  fac_mid_q [N_TERMS-1];

  for (genvar i = 0; i < N_TERMS; i++) begin : g_fac_prod
    assign sin_pf_d[i]      = PF_W'(x2_q) * PF_W'(SIN_RCP[i]);
    assign cos_pf_d[i]      = PF_W'(x2_q) * PF_W'(COS_RCP[i]);
    assign fac_st_d.fs[i]   = FAC_W'((sin_pf_q[i] + HALF_F) >> Q_FRAC);
    assign fac_st_d.fc[i]   = FAC_W'((cos_pf_q[i] + HALF_F) >> Q_FRAC);
  end

  // Sine starts from x, cosine from one.
  assign sin_st_d[0].sgn = pf_x_q[X_W-1];
  assign sin_st_d[0].mag = TERM_W'(pf_x_q[X_W-1] ? -pf_x_q : pf_x_q);
  assign sin_st_d[0].acc = SUM_W'(pf_x_q);
  assign cos_st_d[0].sgn = 1'b0;
  assign cos_st_d[0].mag = ONE_T;
  assign cos_st_d[0].acc = SUM_W'(ONE_T);

  for (genvar i = 0; i < N_TERMS; i++) begin : g_term
    assign sin_mid_d[i].sgn  = sin_st_q[i].sgn;
    assign sin_mid_d[i].prod = PROD_W'(sin_st_q[i].mag) * PROD_W'(fac_st_q[i].fs[i]);
    assign sin_mid_d[i].acc  = sin_st_q[i].acc;
    assign cos_mid_d[i].sgn  = cos_st_q[i].sgn;
    assign cos_mid_d[i].prod = PROD_W'(cos_st_q[i].mag) * PROD_W'(fac_st_q[i].fc[i]);
    assign cos_mid_d[i].acc  = cos_st_q[i].acc;

    assign sin_st_d[i+1] = round_step(sin_mid_q[i]);
    assign cos_st_d[i+1] = round_step(cos_mid_q[i]);

    always_ff @(posedge clk_i) begin
      sin_mid_q[i]  <= sin_mid_d[i];
      cos_mid_q[i]  <= cos_mid_d[i];
      sin_st_q[i+1] <= sin_st_d[i+1];
      cos_st_q[i+1] <= cos_st_d[i+1];
    end

    // Factors ride along only as far as the last term that needs them.
    if (i < N_TERMS - 1) begin : g_fac
      always_ff @(posedge clk_i) begin
        fac_mid_q[i]  <= fac_st_q[i];
        fac_st_q[i+1] <= fac_mid_q[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_mid_q[i]  <= 1'b0;
        vld_st_q[i+1] <= 1'b0;
      end else begin
        vld_mid_q[i]  <= vld_st_q[i];
        vld_st_q[i+1] <= vld_mid_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output
  // ---------------------------------------------------------------------------
  logic                    out_vld_q;
  logic signed [OUT_W-1:0] sine_d, cosine_d;
  logic signed [OUT_W-1:0] sine_q, cosine_q;

  assign sine_d   = out_round(sin_st_q[N_TERMS].acc);
  assign cosine_d = out_round(cos_st_q[N_TERMS].acc);

  // Payload registers of the front stages and the output.
  always_ff @(posedge clk_i) begin
    r1_v_q   <= v_in;
    r1_pos_q <= r1_pos_d;
    r1_neg_q <= r1_neg_d;
    r1_u_q   <= r1_u_d;
    r2_v_q   <= r1_v_q;
    r2_pos_q <= r1_pos_q;
    r2_neg_q <= r1_neg_q;
    r2_k_q   <= r2_k_d;
    r3_v_q   <= r3_v_d;
    r3_pos_q <= r2_pos_q;
    r3_neg_q <= r2_neg_q;
    x_q      <= x_d;
    sq_q     <= sq_d;
    sq_x_q   <= x_q;
    x2_q     <= x2_d;
    x2_x_q   <= sq_x_q;
    for (int i = 0; i < N_TERMS; i++) begin
      sin_pf_q[i] <= sin_pf_d[i];
      cos_pf_q[i] <= cos_pf_d[i];
    end
    pf_x_q      <= x2_x_q;
    fac_st_q[0] <= fac_st_d;
    sin_st_q[0] <= sin_st_d[0];
    cos_st_q[0] <= cos_st_d[0];
    sine_q      <= sine_d;
    cosine_q    <= cosine_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q    <= 1'b0;
      r2_vld_q    <= 1'b0;
      r3_vld_q    <= 1'b0;
      x_vld_q     <= 1'b0;
      sq_vld_q    <= 1'b0;
      x2_vld_q    <= 1'b0;
      pf_vld_q    <= 1'b0;
      vld_st_q[0] <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      r1_vld_q    <= accept;
      r2_vld_q    <= r1_vld_q;
      r3_vld_q    <= r2_vld_q;
      x_vld_q     <= r3_vld_q;
      sq_vld_q    <= x_vld_q;
      x2_vld_q    <= sq_vld_q;
      pf_vld_q    <= x2_vld_q;
      vld_st_q[0] <= pf_vld_q;
      out_vld_q   <= vld_st_q[N_TERMS];
    end
  end

  assign valid_o  = out_vld_q;
  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY valid_o)
    else $error("accepted angle gave no result at the expected cycle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching transfer");

  a_reduced_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_vld_q |-> ((x_q <= X_LIM) && (x_q >= -X_LIM)))
    else $error("reduced angle lies outside [-pi, pi]");

  a_square_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q |-> !sq_q[PROD_W-1])
    else $error("square of the angle came out negative");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sine_cosine_taylor: directed and random angles go in,
// and every sine and cosine result is checked in order against a predicted pair.
// Depends on sct_pkg and the sine_cosine_taylor RTL.
module testbench
  import sct_pkg::*;
();

  localparam int     PER_PHASE    = 400;
  localparam int     STALL_LIMIT  = 600;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     ANGLE_SHIFT  = Q_FRAC - ANGLE_FRAC_BITS_DEF;
  localparam int     OUT_SHIFT    = Q_FRAC - OUT_FRAC_BITS_DEF;
  localparam longint PI_ANG       = longint'((PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS_DEF)))
                                             >> (60 - ANGLE_FRAC_BITS_DEF));
  localparam longint TWO_PI_ANG   = longint'((PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS_DEF)))
                                             >> (59 - ANGLE_FRAC_BITS_DEF));
  localparam longint ONE_Q32      = longint'(1) << Q_FRAC;
  localparam longint OUT_MAX      = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN      = -(longint'(1) << (OUT_W - 1));

  typedef struct packed {
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } trig_t;

  logic                    clk    = 1'b0;
  logic                    rst_n  = 1'b0;
  logic                    start  = 1'b0;
  logic signed [IN_W-1:0]  angle  = '0;
  logic                    busy;
  logic                    valid;
  logic signed [OUT_W-1:0] sine;
  logic signed [OUT_W-1:0] cosine;

  logic signed [IN_W-1:0]  pending_angles [$];
  trig_t                   trig_expected [$];
  trig_t                   oldest;
  int                      n_queued        = 0;
  int                      n_driven        = 0;
  int                      n_accepted      = 0;
  int                      errors          = 0;
  int                      stall_cycles    = 0;
  int                      sender_idle_pct = 8;

  sine_cosine_taylor uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start_i  (start),
    .busy_o   (busy),
    .angle_i  (angle),
    .valid_o  (valid),
    .sine_o   (sine),
    .cosine_o (cosine)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Q32 reciprocal of a series denominator, rounded to nearest.
  function automatic longint recip_q32(int n);
    return longint'(((64'd1 << Q_FRAC) + 64'(n / 2)) / 64'(n));
  endfunction

  // Signed Q32 product, rounded half away from zero.
  function automatic longint q32_mul(longint a, longint b);
    longint unsigned ua;
    longint unsigned ub;
    logic [127:0]    prod;
    longint          mag;
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    prod = (prod + 128'h8000_0000) >> Q_FRAC;
    mag  = longint'({1'b0, prod[62:0]});
    return ((a < 0) != (b < 0)) ? -mag : mag;
  endfunction

  // Q32 to the output format: round half up, then saturate.
  function automatic logic signed [OUT_W-1:0] q32_to_out(longint v);
    longint r;
    r = (v + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  function automatic trig_t sincos_taylor(logic signed [IN_W-1:0] a);
    longint v;
    longint k;
    longint x;
    longint x_sq;
    longint term;
    longint s_sum;
    longint c_sum;
    trig_t  res;
    v = a;
    // The compares are strict, so an angle of exactly pi is left alone.
    if (v > PI_ANG) begin
      k = (v - PI_ANG + TWO_PI_ANG - 1) / TWO_PI_ANG;
      v = v - k * TWO_PI_ANG;
    end else if (v < -PI_ANG) begin
      k = (-PI_ANG - v + TWO_PI_ANG - 1) / TWO_PI_ANG;
      v = v + k * TWO_PI_ANG;
    end
    x     = v * (longint'(1) << ANGLE_SHIFT);
    x_sq  = q32_mul(x, x);
    term  = x;
    s_sum = x;
    for (int i = 0; i < N_TERMS; i++) begin
      term  = -q32_mul(term, q32_mul(x_sq, recip_q32((2 * i + 2) * (2 * i + 3))));
      s_sum = s_sum + term;
    end
    term  = ONE_Q32;
    c_sum = ONE_Q32;
    for (int i = 0; i < N_TERMS; i++) begin
      term  = -q32_mul(term, q32_mul(x_sq, recip_q32((2 * i + 1) * (2 * i + 2))));
      c_sum = c_sum + term;
    end
    res.sine   = q32_to_out(s_sum);
    res.cosine = q32_to_out(c_sum);
    return res;
  endfunction

  function automatic logic signed [IN_W-1:0] random_angle();
    logic signed [IN_W-1:0] a;
    case ($urandom_range(9))
      0, 1, 2: a = $urandom;
      3, 4, 5: a = IN_W'(longint'($urandom_range(32'(2 * PI_ANG))) - PI_ANG);
      6: begin
        a = IN_W'(PI_ANG + longint'($urandom_range(8)) - 4);
        if ($urandom_range(1) == 1) a = -a;
      end
      7: begin
        if ($urandom_range(1) == 1) a = 32'sh7FFF_FFFF - $urandom_range(15);
        else a = 32'sh8000_0000 + $urandom_range(15);
      end
      8: a = IN_W'(longint'($urandom_range(4095)) - 2048);
      default: begin
        a = IN_W'((longint'($urandom_range(10)) - 5) * PI_ANG / 2
                  + longint'($urandom_range(2)) - 1);
      end
    endcase
    return a;
  endfunction

  task automatic queue_angle(logic signed [IN_W-1:0] a);
    pending_angles.push_back(a);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || trig_expected.size() != 0) @(negedge clk);
  endtask

  // Driver: a new angle goes out only once the previous one has been transferred.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && n_accepted != n_driven) begin
      // Held off by busy: the same angle stays on the bus.
    end else if (pending_angles.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      angle <= pending_angles.pop_front();
      start <= 1'b1;
      n_driven++;
    end else begin
      start <= 1'b0;
      angle <= $urandom;
    end
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      stall_cycles++;
      if (start && !busy) begin
        trig_expected.push_back(sincos_taylor(angle));
        n_accepted++;
        stall_cycles = 0;
      end
      if (valid) begin
        stall_cycles = 0;
        if (trig_expected.size() == 0) begin
          $display("%0t: result with none expected, sine %h cosine %h", $time, sine, cosine);
          errors++;
        end else begin
          oldest = trig_expected.pop_front();
          if (sine !== oldest.sine) begin
            $display("%0t: sine mismatch, expected %h, actual %h", $time, oldest.sine, sine);
            errors++;
          end
          if (cosine !== oldest.cosine) begin
            $display("%0t: cosine mismatch, expected %h, actual %h",
                     $time, oldest.cosine, cosine);
            errors++;
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Zero, +-1, field extremes, +-pi and both sides, quarter and full turns.
    queue_angle('0);
    queue_angle(IN_W'(1));
    queue_angle(-IN_W'(1));
    queue_angle(32'sh7FFF_FFFF);
    queue_angle(32'sh8000_0000);
    queue_angle(32'sh4000_0000);
    queue_angle(32'shC000_0000);
    queue_angle(32'sh5555_5555);
    queue_angle(32'shAAAA_AAAA);
    queue_angle(IN_W'(PI_ANG));
    queue_angle(IN_W'(PI_ANG + 1));
    queue_angle(IN_W'(PI_ANG - 1));
    queue_angle(IN_W'(-PI_ANG));
    queue_angle(IN_W'(-PI_ANG - 1));
    queue_angle(IN_W'(-PI_ANG + 1));
    queue_angle(IN_W'(TWO_PI_ANG));
    queue_angle(IN_W'(-TWO_PI_ANG));
    queue_angle(IN_W'(PI_ANG / 2));
    queue_angle(IN_W'(-PI_ANG / 2));
    queue_angle(IN_W'(3 * PI_ANG / 2));
    queue_angle(IN_W'(-3 * PI_ANG / 2));
    queue_angle(IN_W'(PI_ANG + TWO_PI_ANG / 4));
    wait_drained();
    // Each phase starts from an empty pipeline, so the sender pauses in between.
    for (int phase = 0; phase < 3; phase++) begin
      @(posedge clk);
      sender_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 72 : 0;
      repeat (PER_PHASE) queue_angle(random_angle());
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
